>>> rtl/b64e_pkg.sv
// Shared types, constants and the Base64 alphabet for the stream encoder.
package b64e_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] PadChar = 7'h3D;

  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2,
    PhaseSpare  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [SextetW-1:0] s0;
    logic [SextetW-1:0] s1;
    logic [1:0]         cnt_m1;
    logic               eom;
  } job_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [SextetW-1:0] v);
    logic [CharW-1:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      sextet_char = v7 + 7'd65;
    end else if (v < 6'd52) begin
      sextet_char = v7 + 7'd71;
    end else if (v < 6'd62) begin
      sextet_char = v7 - 7'd4;
    end else if (v == 6'd62) begin
      sextet_char = 7'h2B;
    end else begin
      sextet_char = 7'h2F;
    end
  endfunction

endpackage

>>> rtl/b64e_byte_if.sv
// Byte channel: raw message bytes with an end-of-message flag.
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

>>> rtl/b64e_char_if.sv
// Character channel: encoded Base64 characters with a final-character flag.
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

>>> rtl/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: front end, job queue and back end.
//
//   channel    dir   payload                        handshake
//   byte_in    in    data_byte[7:0], end_of_message valid / ready
//   char_out   out   text_char[6:0], last_char      valid / ready
//
// Each byte yields 1 or 2 characters, up to 4 on the final byte.
// The character back end emits one character per cycle while char_out is ready and sets the sustained rate.
// byte_in.ready drops only while the two-entry job queue is full.
// Output is registered; a stalled char_out holds its character and the queue absorbs input.
// Reset clears phase, leftover bits, queue and output valid; no clearing pass.
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  b64e_byte_if.sink    byte_in,
  b64e_char_if.source  char_out
);

  logic push;
  job_t push_job;
  logic full;
  logic avail;
  logic pop;
  job_t pop_job;

  b64e_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_in (byte_in),
    .full_i  (full),
    .push_o  (push),
    .job_o   (push_job)
  );

  b64e_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (full),
    .avail_o    (avail),
    .pop_job_o  (pop_job)
  );

  b64e_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .job_i    (pop_job),
    .pop_o    (pop),
    .char_out (char_out)
  );

endmodule

>>> rtl/b64e_front.sv
// Front end: accepts bytes, tracks the group phase and forms one character job per byte.
module b64e_front
  import b64e_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  b64e_byte_if.sink    byte_in,
  input  logic         full_i,
  output logic         push_o,
  output job_t         job_o
);

  phase_e          phase_q, phase_d;
  logic [3:0]      left_q, left_d;
  logic [ByteW-1:0] b;
  logic            eom;

  assign b              = byte_in.data_byte;
  assign eom            = byte_in.end_of_message;
  assign byte_in.ready  = ~full_i;
  assign push_o         = byte_in.valid & ~full_i;

  always_comb begin
    job_o   = '0;
    phase_d = phase_q;
    left_d  = left_q;
    job_o.eom = eom;
    unique case (phase_q)
      PhaseSecond: begin
        job_o.s0     = {left_q[1:0], b[7:4]};
        job_o.s1     = {b[3:0], 2'b00};
        job_o.cnt_m1 = eom ? 2'd2 : 2'd0;
        left_d       = b[3:0];
        phase_d      = PhaseThird;
      end
      PhaseThird: begin
        job_o.s0     = {left_q[3:0], b[7:6]};
        job_o.s1     = b[5:0];
        job_o.cnt_m1 = 2'd1;
        left_d       = 4'd0;
        phase_d      = PhaseFirst;
      end
      default: begin
        job_o.s0     = b[7:2];
        job_o.s1     = {b[1:0], 4'b0000};
        job_o.cnt_m1 = eom ? 2'd3 : 2'd0;
        left_d       = {2'b00, b[1:0]};
        phase_d      = PhaseSecond;
      end
    endcase
    if (eom) begin
      left_d  = 4'd0;
      phase_d = PhaseFirst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      left_q  <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> rtl/b64e_queue.sv
// Two-entry job queue between the front end and the character back end.
module b64e_queue
  import b64e_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output logic full_o,
  output logic avail_o,
  output job_t pop_job_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_pop;

  assign full_o    = (cnt_q == QueueCntW'(QueueDepth));
  assign avail_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_pop    = pop_i & avail_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/b64e_back.sv
// Back end: walks each job one character per cycle, unless stalled, into a registered output.
module b64e_back
  import b64e_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         avail_i,
  input  job_t         job_i,
  output logic         pop_o,
  b64e_char_if.source  char_out
);

  job_t             cur_q;
  logic             cur_valid_q;
  logic [1:0]       idx_q;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;
  logic             load_out;
  logic             cur_done;
  logic [CharW-1:0] next_char;

  assign load_out = cur_valid_q & (~out_valid_q | char_out.ready);
  assign cur_done = load_out & (idx_q == cur_q.cnt_m1);
  assign pop_o    = ~cur_valid_q | cur_done;

  always_comb begin
    case (idx_q)
      2'd0:    next_char = sextet_char(cur_q.s0);
      2'd1:    next_char = sextet_char(cur_q.s1);
      default: next_char = PadChar;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && avail_i) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (cur_done) begin
        cur_valid_q <= 1'b0;
      end else if (load_out) begin
        idx_q <= idx_q + 2'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (char_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && avail_i) begin
      cur_q <= job_i;
    end
    if (load_out) begin
      out_char_q <= next_char;
      out_last_q <= cur_q.eom & (idx_q == cur_q.cnt_m1);
    end
  end

  assign char_out.valid     = out_valid_q;
  assign char_out.text_char = out_char_q;
  assign char_out.last_char = out_last_q;

endmodule

>>> rtl/b64e_checker.sv
// Port-level checks for the Base64 stream encoder, bound to the top level.
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] text_char_i,
  input logic       last_char_i
);

  logic out_txn;
  logic legal_char;

  assign out_txn    = out_valid_i & out_ready_i;
  assign legal_char = (text_char_i >= 7'h41 && text_char_i <= 7'h5A) ||
                      (text_char_i >= 7'h61 && text_char_i <= 7'h7A) ||
                      (text_char_i >= 7'h30 && text_char_i <= 7'h39) ||
                      (text_char_i == 7'h2B) || (text_char_i == 7'h2F) ||
                      (text_char_i == 7'h3D);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(text_char_i) && $stable(last_char_i))
    else $error("stalled character changed");

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> legal_char)
    else $error("character outside the Base64 alphabet");

  a_pad_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_txn && text_char_i == 7'h3D && !last_char_i |=>
      out_valid_i && text_char_i == 7'h3D && last_char_i)
    else $error("first padding character not followed by final padding");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (char_out.valid),
  .out_ready_i (char_out.ready),
  .text_char_i (char_out.text_char),
  .last_char_i (char_out.last_char)
);

>>> tb/tb_base64_stream_encoder.sv
// Self-checking testbench for the Base64 stream encoder: directed and random traffic with idling.
`timescale 1ns / 1ps

module tb_base64_stream_encoder
  import b64e_pkg::*;
();

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_message;
  } msg_byte_t;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             last_char;
  } enc_char_t;

  localparam logic [8*64-1:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk_i;
  logic rst_ni;

  b64e_byte_if byte_if ();
  b64e_char_if char_if ();

  base64_stream_encoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_in (byte_if),
    .char_out(char_if)
  );

  msg_byte_t   pending_bytes[$];
  enc_char_t   expected_chars[$];
  phase_e      enc_phase      = PhaseFirst;
  logic [3:0]  enc_carry      = '0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  bit          byte_fired     = 1'b0;
  bit          calm;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [CharW-1:0] b64_char(input logic [SextetW-1:0] sextet);
    return B64Alphabet[8*(63-sextet) +: CharW];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_char(input logic [CharW-1:0] ch, input logic last);
    enc_char_t c;
    c.text_char = ch;
    c.last_char = last;
    expected_chars = {expected_chars, c};
  endtask

  task automatic encode_byte(input msg_byte_t it);
    case (enc_phase)
      PhaseSecond: begin
        push_char(b64_char({enc_carry[1:0], it.data_byte[7:4]}), 1'b0);
        enc_carry = it.data_byte[3:0];
        enc_phase = PhaseThird;
      end
      PhaseThird: begin
        push_char(b64_char({enc_carry, it.data_byte[7:6]}), 1'b0);
        push_char(b64_char(it.data_byte[5:0]), it.end_of_message);
        enc_carry = '0;
        enc_phase = PhaseFirst;
      end
      default: begin
        push_char(b64_char(it.data_byte[7:2]), 1'b0);
        enc_carry = {2'b00, it.data_byte[1:0]};
        enc_phase = PhaseSecond;
      end
    endcase
    if (it.end_of_message) begin
      case (enc_phase)
        PhaseSecond: begin
          push_char(b64_char({enc_carry[1:0], 4'b0000}), 1'b0);
          push_char(PadChar, 1'b0);
          push_char(PadChar, 1'b1);
        end
        PhaseThird: begin
          push_char(b64_char({enc_carry, 2'b00}), 1'b0);
          push_char(PadChar, 1'b1);
        end
        default: ;
      endcase
      enc_carry = '0;
      enc_phase = PhaseFirst;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic queue_message(input int unsigned len);
    msg_byte_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.data_byte      = $urandom_range(0, 255);
      it.end_of_message = (i == len - 1);
      pending_bytes = {pending_bytes, it};
    end
  endtask

  task automatic queue_bytes(input logic [ByteW-1:0] bytes[$]);
    msg_byte_t it;
    foreach (bytes[i]) begin
      it.data_byte      = bytes[i];
      it.end_of_message = (i == bytes.size() - 1);
      pending_bytes = {pending_bytes, it};
    end
  endtask

  task automatic queue_random(input int unsigned total);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < total) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      queue_message(len);
      sent += len;
    end
  endtask

  task automatic drain_pending();
    while (pending_bytes.size() != 0 || byte_if.valid) @(posedge clk_i);
  endtask

  // Driver: present the next byte at the falling edge once the previous one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else if (byte_fired || !byte_if.valid) begin
      byte_fired = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        byte_if.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        msg_byte_t it;
        it = pending_bytes.pop_front();
        byte_if.valid          <= 1'b1;
        byte_if.data_byte      <= it.data_byte;
        byte_if.end_of_message <= it.end_of_message;
        send_gap = pick_gap();
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Sink: stall the character channel at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      char_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      char_if.ready <= 1'b0;
    end else begin
      char_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Monitor: predict on each byte transaction, check each character transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        msg_byte_t it;
        it.data_byte      = byte_if.data_byte;
        it.end_of_message = byte_if.end_of_message;
        encode_byte(it);
        byte_fired = 1'b1;
      end
      if (char_if.valid && char_if.ready) begin
        enc_char_t want;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    char_if.text_char, char_if.last_char));
        end else begin
          want = expected_chars.pop_front();
          if (char_if.text_char !== want.text_char)
            report_mismatch($sformatf("text_char got 0x%02h want 0x%02h",
                                      char_if.text_char, want.text_char));
          if (char_if.last_char !== want.last_char)
            report_mismatch($sformatf("last_char got %0b want %0b (char 0x%02h)",
                                      char_if.last_char, want.last_char, want.text_char));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    calm   = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // One-, two- and three-byte tails, extremes of the byte and the alphabet's ends A, + and /.
    queue_bytes('{8'h00});
    queue_bytes('{8'hFF});
    queue_bytes('{8'h00, 8'hFF});
    queue_bytes('{8'hFF, 8'h00});
    queue_bytes('{8'hFB, 8'hFF, 8'hBF});
    queue_bytes('{8'h4D, 8'h61, 8'h6E, 8'h00});
    queue_bytes('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    drain_pending();

    queue_random(120);
    drain_pending();
    calm = 1'b1;
    queue_random(90);
    drain_pending();
    calm = 1'b0;
    queue_random(120);
    drain_pending();

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
